// ===== src/bsb_pkg.sv =====
// Shared types, constants and the clamped knot function for the B-spline
// basis evaluator. No dependencies; every other file imports this package.
`default_nettype none

package bsb_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS     = 16;
    localparam int MAX_ORDER_DEF = 8;
    localparam int MAX_POINTS    = 256;
    localparam int LAST_MAX      = MAX_POINTS - 1;
    localparam int IDX_W         = 8;
    localparam int ORD_W         = 4;
    localparam int T_W           = 24;
    localparam int CFG_W         = 8;

    // Knot index and knot value widths (index reaches 255 + the order)
    localparam int KIW = 10;
    localparam int KW  = 10;

    // Datapath widths: signed distance, magnitude, node value, product,
    // quotient and term accumulator
    localparam int DW = KW + FRAC_BITS + 1;
    localparam int MW = DW - 1;
    localparam int VW = FRAC_BITS + 1;
    localparam int PW = MW + VW;
    localparam int XW = PW - FRAC_BITS;
    localparam int AW = XW + 2;
    localparam int CW = $clog2(XW);

    localparam logic [VW-1:0]    ONE_FX   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [IDX_W-1:0] LAST_RST = 8'd3;
    localparam logic [ORD_W-1:0] ORD_RST  = 4'd4;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_LAST_INDEX = 1'b0,
        CFG_KNOT_ORDER = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [IDX_W-1:0] last;
        logic [ORD_W-1:0] ord;
    } t_cfg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SETUP,
        S_WAIT,
        S_WRITE,
        S_DONE
    } t_state;

    // Multiply-divide unit states
    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } t_unit_state;

    typedef struct packed {
        logic          start;
        logic [MW-1:0] mag;
        logic [VW-1:0] weight;
        logic [KW-1:0] span;
    } t_term_req;

    typedef struct packed {
        logic          done;
        logic [XW-1:0] quot;
    } t_term_rsp;

    // Clamped uniform knot vector: zero below the order, flat above last
    function automatic logic signed [KW-1:0] knot_at(
        input logic [KIW-1:0]   k,
        input logic [ORD_W-1:0] ord,
        input logic [IDX_W-1:0] last
    );
        logic signed [KW:0] ks;
        logic signed [KW:0] os;
        logic signed [KW:0] ls;
        logic signed [KW:0] r;
        ks = signed'({{(KW + 1 - KIW){1'b0}}, k});
        os = signed'({{(KW + 1 - ORD_W){1'b0}}, ord});
        ls = signed'({{(KW + 1 - IDX_W){1'b0}}, last});
        if (ks < os) begin
            r = '0;
        end else if (ks > ls) begin
            r = ls - os + (KW + 1)'(2);
        end else begin
            r = ks - os + (KW + 1)'(1);
        end
        return r[KW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/bsb_term_unit.sv =====
// Shared multiply-divide unit: |dist| * weight / (span * 2^FRAC_BITS),
// truncated. A multiply step, then one restoring quotient bit a cycle.
`default_nettype none

module bsb_term_unit import bsb_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_term_req i_req,
    output t_term_rsp      o_rsp
);

    t_unit_state   r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [MW-1:0] r_dist;
    logic [VW-1:0] r_weight;
    logic [KW-1:0] r_span;
    logic [KW-1:0] r_rem;
    logic [XW-1:0] r_quo;

    logic [PW-1:0] w_prod;
    logic [KW:0]   w_rem_sh;
    logic          w_ge;
    logic [KW:0]   w_rem_sub;
    logic          w_last;

    // Product and one restoring division step
    always_comb begin
        w_prod    = {{VW{1'b0}}, r_dist} * {{MW{1'b0}}, r_weight};
        w_rem_sh  = {r_rem, r_quo[XW-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_span});
        w_rem_sub = w_ge ? (w_rem_sh - {1'b0, r_span}) : w_rem_sh;
        w_last    = (r_cnt == CW'(XW - 1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) n_state = U_MUL;
            end
            U_MUL: begin
                n_state = U_DIV;
            end
            U_DIV: begin
                if (w_last) n_state = U_IDLE;
            end
            default: n_state = U_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.done = r_done;
        o_rsp.quot = r_quo;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == U_DIV) && w_last;
            if (r_state == U_DIV) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Operand capture, product load, quotient shift
    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    r_dist   <= i_req.mag;
                    r_weight <= i_req.weight;
                    r_span   <= i_req.span;
                end
            end
            U_MUL: begin
                r_quo <= w_prod[PW-1:FRAC_BITS];
                r_rem <= '0;
            end
            U_DIV: begin
                r_rem <= w_rem_sub[KW-1:0];
                r_quo <= {r_quo[XW-2:0], w_ge};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == U_IDLE)
        else $error("term unit started while busy");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == U_DIV |-> r_span != '0)
        else $error("division by a zero span");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire

// ===== src/bsb_ctrl.sv =====
// Sequencer for the Cox-de Boor triangle: order-1 level, then every node
// as two terms on the shared unit. Uses bsb_pkg; drives bsb_term_unit.
`default_nettype none

module bsb_ctrl import bsb_pkg::*; #(
    parameter  int MAX_ORDER = MAX_ORDER_DEF,
    localparam int NW        = $clog2(MAX_ORDER + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [NW-1:0]    i_order,
    input  wire logic [T_W-1:0]   i_t,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [VW-1:0]         o_value,
    output t_term_req             o_req,
    input  wire t_term_rsp        i_rsp
);

    localparam int JW = $clog2(MAX_ORDER);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_i;
    logic [NW-1:0]       r_n;
    logic [NW-1:0]       r_j;
    logic [NW-1:0]       r_m;
    logic                r_term;
    logic [T_W-1:0]      r_t;
    logic                r_sign;
    logic signed [AW-1:0] r_acc;
    logic [VW-1:0]       r_node [MAX_ORDER];
    logic                r_out_valid;
    logic [VW-1:0]       r_out_value;

    logic [KIW-1:0]       w_base;
    logic [KIW-1:0]       w_lo_idx;
    logic [KIW-1:0]       w_hi_idx;
    logic signed [KW-1:0] w_k_lo;
    logic signed [KW-1:0] w_k_hi;
    logic signed [DW-1:0] w_kl_fx;
    logic signed [DW-1:0] w_kh_fx;
    logic signed [DW-1:0] w_t_fx;
    logic signed [DW-1:0] w_dist;
    logic signed [DW-1:0] w_dist_abs;
    logic signed [KW:0]   w_span;
    logic signed [KW:0]   w_span_abs;
    logic                 w_on;
    logic [NW-1:0]        w_rd_sum;
    logic [VW-1:0]        w_lower;
    logic                 w_skip;
    logic                 w_sign;
    logic signed [AW-1:0] w_q;
    logic signed [AW-1:0] w_acc_next;
    logic [VW-1:0]        w_clamped;
    logic                 w_accept;
    logic                 w_load_out;
    logic                 w_last_j_init;
    logic                 w_last_j;
    logic                 w_last_m;

    // Knot pair, distance, span and node operand of the current term
    always_comb begin
        w_base   = KIW'(r_i) + KIW'(r_j);
        w_lo_idx = w_base + KIW'(r_term);
        if (r_state == S_INIT) begin
            w_hi_idx = w_base + KIW'(1);
        end else begin
            w_hi_idx = w_base + KIW'(r_term) + KIW'(r_m) - KIW'(1);
        end
        w_k_lo  = knot_at(w_lo_idx, i_cfg.ord, i_cfg.last);
        w_k_hi  = knot_at(w_hi_idx, i_cfg.ord, i_cfg.last);
        w_kl_fx = $signed({{(DW - KW - FRAC_BITS){w_k_lo[KW-1]}}, w_k_lo,
                           {FRAC_BITS{1'b0}}});
        w_kh_fx = $signed({{(DW - KW - FRAC_BITS){w_k_hi[KW-1]}}, w_k_hi,
                           {FRAC_BITS{1'b0}}});
        w_t_fx  = $signed({{(DW - T_W){1'b0}}, r_t});

        // Order-1 span test, closed at the curve end
        w_on = ((w_kl_fx <= w_t_fx) && (w_t_fx < w_kh_fx)) ||
               ((w_t_fx == w_kh_fx) && (w_lo_idx == KIW'(i_cfg.last)));

        w_dist     = r_term ? (w_kh_fx - w_t_fx) : (w_t_fx - w_kl_fx);
        w_dist_abs = w_dist[DW-1] ? -w_dist : w_dist;
        w_span     = $signed({w_k_hi[KW-1], w_k_hi}) - $signed({w_k_lo[KW-1], w_k_lo});
        w_span_abs = w_span[KW] ? -w_span : w_span;
        w_sign     = w_dist[DW-1] ^ w_span[KW];

        w_rd_sum = r_j + NW'(r_term);
        w_lower  = r_node[w_rd_sum[JW-1:0]];
        // Zero span drops the term; a zero node gives a zero term
        w_skip   = (w_span == '0) || (w_lower == '0);
    end

    // Term accumulation and node clamp
    always_comb begin
        w_q        = $signed({{(AW - XW){1'b0}}, i_rsp.quot});
        w_acc_next = r_sign ? (r_acc - w_q) : (r_acc + w_q);
        if (r_acc[AW-1]) begin
            w_clamped = '0;
        end else if (r_acc > $signed({{(AW - VW){1'b0}}, ONE_FX})) begin
            w_clamped = ONE_FX;
        end else begin
            w_clamped = r_acc[VW-1:0];
        end
    end

    // Loop bounds and handshakes
    always_comb begin
        w_accept      = i_in_valid && (r_state == S_IDLE);
        w_load_out    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        w_last_j_init = (r_j == r_n - NW'(1));
        w_last_j      = (r_j == r_n - r_m);
        w_last_m      = (r_m == r_n);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_order == '0) ? S_DONE : S_INIT;
                end
            end
            S_INIT: begin
                if (w_last_j_init) begin
                    n_state = (r_n == NW'(1)) ? S_DONE : S_SETUP;
                end
            end
            S_SETUP: begin
                if (!w_skip) begin
                    n_state = S_WAIT;
                end else if (r_term) begin
                    n_state = S_WRITE;
                end
            end
            S_WAIT: begin
                if (i_rsp.done) begin
                    n_state = r_term ? S_WRITE : S_SETUP;
                end
            end
            S_WRITE: begin
                n_state = (w_last_j && w_last_m) ? S_DONE : S_SETUP;
            end
            S_DONE: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_out_valid  = r_out_valid;
        o_value      = r_out_value;
        o_req.start  = (r_state == S_SETUP) && !w_skip;
        o_req.mag    = w_dist_abs[MW-1:0];
        o_req.weight = w_lower;
        o_req.span   = w_span_abs[KW-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item fields, loop counters, accumulator and node row
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_i    <= i_index;
                    r_n    <= i_order;
                    r_t    <= i_t;
                    r_j    <= '0;
                    r_term <= 1'b0;
                end
            end
            S_INIT: begin
                r_node[r_j[JW-1:0]] <= w_on ? ONE_FX : '0;
                if (w_last_j_init) begin
                    r_j    <= '0;
                    r_m    <= NW'(2);
                    r_term <= 1'b0;
                    r_acc  <= '0;
                end else begin
                    r_j <= r_j + NW'(1);
                end
            end
            S_SETUP: begin
                if (!w_skip) begin
                    r_sign <= w_sign;
                end else if (!r_term) begin
                    r_term <= 1'b1;
                end
            end
            S_WAIT: begin
                if (i_rsp.done) begin
                    r_acc <= w_acc_next;
                    if (!r_term) r_term <= 1'b1;
                end
            end
            S_WRITE: begin
                r_node[r_j[JW-1:0]] <= w_clamped;
                r_acc  <= '0;
                r_term <= 1'b0;
                if (w_last_j) begin
                    r_j <= '0;
                    r_m <= r_m + NW'(1);
                end else begin
                    r_j <= r_j + NW'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    r_out_value <= (r_n == '0) ? '0 : r_node[0];
                end
            end
            default: begin
                r_term <= 1'b0;
            end
        endcase
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.done |-> r_state == S_WAIT)
        else $error("term result arrived outside the wait state");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SETUP |-> (r_m >= NW'(2)) && (r_m <= r_n))
        else $error("triangle level out of range");

    a_value_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_value <= ONE_FX)
        else $error("basis value above one");

endmodule

`default_nettype wire

// ===== src/bspline_basis_eval_top.sv =====
// Top level of the B-spline basis evaluator: configuration registers,
// order clamp, sequencer and shared multiply-divide unit. Uses bsb_pkg.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    control_index, basis_order, param_t
//   out       output     o_out_valid / i_out_ready  basis_value
//   cfg       input      i_cfg_we                   i_cfg_addr, i_cfg_data
//
// One item at a time. Order 0 goes straight to a zero result; otherwise
// the order-1 level is set first, then per triangle node two terms and a write.
// On the shared unit a term is a multiply, 27 quotient bits and a hand-back;
// a term with a zero span or zero lower node is skipped. Synchronous
// active-low reset
// restores last_index 3 and knot_order 4. The result waits in an output
// register, so the next item is taken while it stalls.
`default_nettype none

module bspline_basis_eval_top import bsb_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [IDX_W-1:0] i_control_index,
    input  wire logic [ORD_W-1:0] i_basis_order,
    input  wire logic [T_W-1:0]   i_param_t,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [VW-1:0]         o_basis_value,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int NW = $clog2(MAX_ORDER + 1);

    t_cfg          r_cfg, n_cfg;
    logic [NW-1:0] w_order;
    t_term_req     w_req;
    t_term_rsp     w_rsp;

    // Register writes; saturate last_index to the last point index (LAST_MAX)
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_LAST_INDEX: begin
                    if (int'(i_cfg_data) > LAST_MAX) begin
                        n_cfg.last = IDX_W'(LAST_MAX);
                    end else begin
                        n_cfg.last = i_cfg_data[IDX_W-1:0];
                    end
                end
                CFG_KNOT_ORDER: begin
                    n_cfg.ord = i_cfg_data[ORD_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.last <= LAST_RST;
            r_cfg.ord  <= ORD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Clamp the requested order to the triangle depth
    always_comb begin
        if (int'(i_basis_order) > MAX_ORDER) begin
            w_order = NW'(MAX_ORDER);
        end else begin
            w_order = NW'(i_basis_order);
        end
    end

    bsb_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_index     (i_control_index),
        .i_order     (w_order),
        .i_t         (i_param_t),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_basis_value),
        .o_req       (w_req),
        .i_rsp       (w_rsp)
    );

    bsb_term_unit u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

endmodule

`default_nettype wire
